FILE: rtl/core/priority_inheritance_table_top_macros.svh
// assertion macros for the priority inheritance table
`ifndef PRIORITY_INHERITANCE_TABLE_TOP_MACROS_SVH
`define PRIORITY_INHERITANCE_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pit_pkg.sv
// shared types, codes and helpers of the priority inheritance table
package pit_pkg;

	localparam int QUEUE_LEVELS = 8;
	localparam int QW = 3;
	localparam int IDW = 8;
	localparam int SW = 16;

	typedef enum logic [1:0] {
		OP_APPLY   = 2'd0,
		OP_RESTORE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_WAITER  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t        opcode;
		logic [IDW-1:0] holder_id;
		logic [QW-1:0]  holder_queue;
		logic [SW-1:0]  holder_score;
		logic [IDW-1:0] waiter_id;
		logic [QW-1:0]  waiter_queue;
		logic [SW-1:0]  waiter_score;
	} req_t;

	typedef struct packed {
		logic           changed;
		logic [QW-1:0]  new_queue;
		logic [SW-1:0]  new_score;
		logic           found;
		logic [IDW-1:0] found_waiter;
		logic           status;
	} rsp_t;

	typedef struct packed {
		logic [IDW-1:0] holder;
		logic [IDW-1:0] waiter;
		logic [QW-1:0]  queue;
		logic [SW-1:0]  score;
	} rec_t;

	// saturate a queue level to the last legal level
	function automatic logic [QW-1:0] clamp_queue(input logic [QW-1:0] q);
		logic [QW-1:0] r;
		r = q;
		if (int'(q) >= QUEUE_LEVELS) begin
			r = QW'(QUEUE_LEVELS - 1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/pit_chan_if.sv
// valid/ready channel carrying one payload per transaction
interface pit_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/priority_inheritance_table_top.sv
// priority inheritance table: ordered record memory with scan and compacting removal
// apply, or any lookup on an empty table: goes from idle straight to done, with no scan
// query/get waiter/restore: scan the records oldest first until the holder matches or the last is read
// a restore hit then compacts the table, moving each later record one place toward the head
// one transaction in flight; the next is accepted while a result waits in the output register
// arst_n clears the fsm, record count and output valid; record contents are never cleared
`include "priority_inheritance_table_top_macros.svh"

module priority_inheritance_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	pit_chan_if.sink   req,
	pit_chan_if.source rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// captured transaction and result waiting for the output register
	pit_pkg::req_t req_q;
	logic [pit_pkg::QW-1:0] hq_q;
	pit_pkg::rsp_t res_q;

	// output register
	logic          out_valid_q;
	pit_pkg::rsp_t out_data_q;

	// record memory, one write and one registered read port
	pit_pkg::rec_t rec_mem_q [TABLE_DEPTH];
	pit_pkg::rec_t rd_data_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	pit_pkg::rec_t wr_data;

	// count, issue pointer, index of the data in rd_data_q, read pending
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] dix_q;
	logic          pend_q;
	logic [CW-1:0] dst_idx;

	// input side decode on the accepting cycle
	logic                   acc;
	logic [pit_pkg::QW-1:0] hq_in, wq_in;
	logic                   boost;
	logic                   apply_boost;
	logic                   full;
	logic                   append;
	logic                   hit;
	logic                   last;
	logic                   remove_done;
	logic                   out_load;

	assign req.ready   = (state_q == ST_IDLE);
	assign acc         = req.valid && req.ready;
	assign hq_in       = pit_pkg::clamp_queue(req.data.holder_queue);
	assign wq_in       = pit_pkg::clamp_queue(req.data.waiter_queue);
	assign boost       = (wq_in < hq_in);
	assign apply_boost = (req.data.opcode == pit_pkg::OP_APPLY) && boost;
	assign full        = (cnt_q == CW'(TABLE_DEPTH));
	assign append      = acc && apply_boost && !full;

	// scan compare on the record read last cycle
	assign hit  = pend_q && (rd_data_q.holder == req_q.holder_id);
	assign last = pend_q && (dix_q == cnt_q - 1'b1);

	// removal done, one record fewer
	assign remove_done = (state_q == ST_SHIFT) && (state_d == ST_DONE);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	// memory port control
	assign dst_idx = dix_q - 1'b1;
	always_comb begin
		rd_en   = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ptr_q < cnt_q);
		rd_addr = ptr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = cnt_q[IW-1:0];
		wr_data = '{holder: req.data.holder_id, waiter: req.data.waiter_id,
			queue: hq_in, score: req.data.holder_score};
		if (state_q == ST_SHIFT) begin
			// move the record one place toward the head
			wr_en   = pend_q;
			wr_addr = dst_idx[IW-1:0];
			wr_data = rd_data_q;
		end else if (append) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rec_mem_q[rd_addr];
		end
		if (wr_en) begin
			rec_mem_q[wr_addr] <= wr_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (req.data.opcode == pit_pkg::OP_APPLY || cnt_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (req_q.opcode == pit_pkg::OP_RESTORE) ? ST_SHIFT : ST_DONE;
				end else if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (!pend_q && !(ptr_q < cnt_q)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			dix_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (remove_done) begin
				cnt_q <= cnt_q - 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					ptr_q  <= '0;
					pend_q <= 1'b0;
				end
				ST_SCAN: begin
					if (hit) begin
						// compaction starts at the entry after the hit
						ptr_q  <= dix_q + 1'b1;
						pend_q <= 1'b0;
					end else begin
						pend_q <= (ptr_q < cnt_q);
						dix_q  <= ptr_q;
						ptr_q  <= ptr_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					pend_q <= (ptr_q < cnt_q);
					if (ptr_q < cnt_q) begin
						dix_q <= ptr_q;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req.data;
			hq_q  <= hq_in;
			// apply result, or the miss result of any lookup
			res_q.changed      <= apply_boost;
			res_q.new_queue    <= apply_boost ? wq_in : hq_in;
			res_q.new_score    <= apply_boost ? req.data.waiter_score : req.data.holder_score;
			res_q.found        <= 1'b0;
			res_q.found_waiter <= '0;
			res_q.status       <= apply_boost && full;
		end
		if (state_q == ST_SCAN && hit) begin
			res_q.found        <= 1'b1;
			res_q.found_waiter <= rd_data_q.waiter;
			if (req_q.opcode == pit_pkg::OP_RESTORE) begin
				res_q.changed   <= 1'b1;
				res_q.new_queue <= rd_data_q.queue;
				res_q.new_score <= rd_data_q.score;
			end else begin
				res_q.new_queue <= hq_q;
				res_q.new_score <= req_q.holder_score;
			end
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	// checks
	`PIT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "record count above depth")
	`PIT_ASSERT_NEXT(a_append_cnt, append, cnt_q == $past(cnt_q) + 1'b1, "append lost a record")
	`PIT_ASSERT_NEXT(a_remove_cnt, remove_done, cnt_q == $past(cnt_q) - 1'b1, "removal miscounted")
	`PIT_ASSERT_NOW(a_scan_index, pend_q, dix_q < cnt_q, "read data beyond count")
	`PIT_ASSERT_NEXT(a_scan_cnt, state_q == ST_SCAN, $stable(cnt_q), "count moved during scan")

endmodule

FILE: tb/tb.sv
// self-checking testbench of the priority inheritance table: directed and random transactions
module tb;

	localparam int TABLE_DEPTH  = 16;
	localparam int N_RANDOM     = 950;
	// longest restore: full scan plus compaction of the whole table, with margin
	localparam int DRAIN_CYCLES = 100;
	// long receiver hold-off so the block backs up and stalls its input
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	// idling phase boundaries, counted in accepted requests
	localparam int PHASE1_AT    = 325;
	localparam int PHASE2_AT    = 650;
	localparam int POOL_SIZE    = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pit_chan_if #(.T(pit_pkg::req_t)) req_ch ();
	pit_chan_if #(.T(pit_pkg::rsp_t)) rsp_ch ();

	priority_inheritance_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// requests not yet offered, and responses predicted but not yet seen
	pit_pkg::req_t pending_req[$];
	pit_pkg::rsp_t expected_rsp[$];

	// shadow copy of the inheritance records, oldest first
	pit_pkg::rec_t shadow_rec[TABLE_DEPTH];
	int   shadow_count = 0;

	int n_sent    = 0;
	int n_results = 0;
	int n_errors  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// small set of holder ids so restores and queries find records
	logic [pit_pkg::IDW-1:0] holder_pool[POOL_SIZE];

	// two-delay clock, period 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle percentage of each side for the current phase of the run
	function automatic int idle_pct(input bit receiver);
		if (n_sent < PHASE1_AT) begin
			return receiver ? 67 : 31;
		end else if (n_sent < PHASE2_AT) begin
			return receiver ? 31 : 67;
		end
		return 0;
	endfunction

	// saturate a queue level at the last legal level
	function automatic logic [pit_pkg::QW-1:0] sat_level(input logic [pit_pkg::QW-1:0] q);
		if (int'(q) >= pit_pkg::QUEUE_LEVELS) begin
			return pit_pkg::QW'(pit_pkg::QUEUE_LEVELS - 1);
		end
		return q;
	endfunction

	// work out the response of one request and update the shadow records
	function automatic pit_pkg::rsp_t predict_inheritance(input pit_pkg::req_t it);
		pit_pkg::rsp_t          r;
		logic [pit_pkg::QW-1:0] hq;
		logic [pit_pkg::QW-1:0] wq;
		int                     idx;
		hq = sat_level(it.holder_queue);
		wq = sat_level(it.waiter_queue);
		// unused fields echo the holder or stay zero
		r.changed      = 1'b0;
		r.new_queue    = hq;
		r.new_score    = it.holder_score;
		r.found        = 1'b0;
		r.found_waiter = '0;
		r.status       = 1'b0;
		if (it.opcode == pit_pkg::OP_APPLY) begin
			// boost only when the waiter is strictly more urgent
			if (wq < hq) begin
				r.changed   = 1'b1;
				r.new_queue = wq;
				r.new_score = it.waiter_score;
				if (shadow_count < TABLE_DEPTH) begin
					shadow_rec[shadow_count] = '{it.holder_id, it.waiter_id, hq, it.holder_score};
					shadow_count++;
				end else begin
					// table full: boost still applies, record dropped
					r.status = 1'b1;
				end
			end
		end else begin
			// oldest record of this holder
			idx = -1;
			for (int i = 0; i < shadow_count; i++) begin
				if (idx < 0 && shadow_rec[i].holder == it.holder_id) begin
					idx = i;
				end
			end
			if (idx >= 0) begin
				r.found        = 1'b1;
				r.found_waiter = shadow_rec[idx].waiter;
				if (it.opcode == pit_pkg::OP_RESTORE) begin
					r.changed   = 1'b1;
					r.new_queue = shadow_rec[idx].queue;
					r.new_score = shadow_rec[idx].score;
					// order-preserving removal
					for (int i = idx; i + 1 < shadow_count; i++) begin
						shadow_rec[i] = shadow_rec[i + 1];
					end
					shadow_count--;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		n_errors++;
		$display("mismatch on response %0d: %s got %0h expected %0h",
			n_results, what, got, want);
	endtask

	// compare one response with the oldest prediction, field by field
	task automatic check_result(input pit_pkg::rsp_t got);
		pit_pkg::rsp_t want;
		n_results++;
		if (expected_rsp.size() == 0) begin
			report_mismatch("unexpected response", 32'(got), 32'd0);
			return;
		end
		want = expected_rsp.pop_front();
		if (got.changed !== want.changed) begin
			report_mismatch("changed", 32'(got.changed), 32'(want.changed));
		end
		if (got.new_queue !== want.new_queue) begin
			report_mismatch("new_queue", 32'(got.new_queue), 32'(want.new_queue));
		end
		if (got.new_score !== want.new_score) begin
			report_mismatch("new_score", 32'(got.new_score), 32'(want.new_score));
		end
		if (got.found !== want.found) begin
			report_mismatch("found", 32'(got.found), 32'(want.found));
		end
		if (got.found_waiter !== want.found_waiter) begin
			report_mismatch("found_waiter", 32'(got.found_waiter), 32'(want.found_waiter));
		end
		if (got.status !== want.status) begin
			report_mismatch("status", 32'(got.status), 32'(want.status));
		end
	endtask

	function automatic pit_pkg::req_t make_req(input pit_pkg::opcode_t op, input int hid,
			input int hq, input int hs, input int wid, input int wq, input int ws);
		pit_pkg::req_t it;
		it.opcode       = op;
		it.holder_id    = pit_pkg::IDW'(hid);
		it.holder_queue = pit_pkg::QW'(hq);
		it.holder_score = pit_pkg::SW'(hs);
		it.waiter_id    = pit_pkg::IDW'(wid);
		it.waiter_queue = pit_pkg::QW'(wq);
		it.waiter_score = pit_pkg::SW'(ws);
		return it;
	endfunction

	// random content; boost forces the waiter strictly more urgent than the holder
	function automatic pit_pkg::req_t random_req(input pit_pkg::opcode_t op,
			input logic [pit_pkg::IDW-1:0] hid, input bit boost);
		int hq;
		int wq;
		if (boost) begin
			hq = $urandom_range(pit_pkg::QUEUE_LEVELS - 1, 1);
			wq = $urandom_range(hq - 1, 0);
		end else begin
			hq = $urandom_range(pit_pkg::QUEUE_LEVELS - 1);
			wq = $urandom_range(pit_pkg::QUEUE_LEVELS - 1);
		end
		return make_req(op, hid, hq, $urandom_range(16'hffff), $urandom_range(255), wq,
			$urandom_range(16'hffff));
	endfunction

	function automatic logic [pit_pkg::IDW-1:0] pick_holder();
		return holder_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// append one request at the tail of the pending queue
	task automatic add_req(input pit_pkg::req_t it);
		pending_req.insert(pending_req.size(), it);
	endtask

	// driver: offer the next pending request whenever the channel is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			n_sent       <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				n_sent <= n_sent + 1;
			end
			// free when nothing was offered or the offer was just taken
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pending_req.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off of the receiver, counted in its own process
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_sent >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: check responses first, then predict the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_result(rsp_ch.data);
			end
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.insert(expected_rsp.size(), predict_inheritance(req_ch.data));
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n_gen;
		int r;
		int n;
		int pick;
		pit_pkg::opcode_t op;

		holder_pool[0] = '0;
		holder_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			holder_pool[i] = pit_pkg::IDW'($urandom_range(255));
		end

		// directed: empty table lookups
		add_req(make_req(pit_pkg::OP_QUERY, 8'h00, 0, 0, 0, 0, 0));
		add_req(make_req(pit_pkg::OP_RESTORE, 8'hff, 7, 16'hffff, 8'hff, 7, 16'hffff));
		// no boost when the waiter is not more urgent
		add_req(make_req(pit_pkg::OP_APPLY, 8'h11, 3, 16'h0f0f, 8'h22, 3, 16'hf0f0));
		// boosts at the extremes, two records for one holder
		add_req(make_req(pit_pkg::OP_APPLY, 8'h00, 7, 16'hffff, 8'hff, 0, 16'h0000));
		add_req(make_req(pit_pkg::OP_APPLY, 8'hff, 5, 16'h0000, 8'h00, 2, 16'hffff));
		add_req(make_req(pit_pkg::OP_APPLY, 8'h00, 6, 16'h1234, 8'h5a, 1, 16'habcd));
		add_req(make_req(pit_pkg::OP_QUERY, 8'h00, 2, 16'h7777, 0, 0, 0));
		add_req(make_req(pit_pkg::OP_WAITER, 8'h00, 4, 16'h8888, 0, 0, 0));
		// restore takes the oldest record and keeps the rest in order
		add_req(make_req(pit_pkg::OP_RESTORE, 8'h00, 0, 16'h0001, 0, 0, 0));
		add_req(make_req(pit_pkg::OP_WAITER, 8'h00, 1, 16'h0002, 0, 0, 0));
		// fill the table, then overflow it
		for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
			add_req(make_req(pit_pkg::OP_APPLY, 8'h80 + i, 4, 16'h8000 + i, 8'h40 + i,
				1, 16'h00ff));
		end
		add_req(make_req(pit_pkg::OP_APPLY, 8'h3c, 7, 16'h5555, 8'hc3, 0, 16'haaaa));

		// random part: mostly pooled holders and real boosts, some bursts and noise
		n_gen = 0;
		while (n_gen < N_RANDOM) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// burst of boosts, often runs into a full table
				n = $urandom_range(20, 12);
				repeat (n) add_req(random_req(pit_pkg::OP_APPLY, pick_holder(), 1'b1));
				n_gen += n;
			end else if (r < 16) begin
				// burst of restores, removes records from the table
				n = $urandom_range(20, 8);
				repeat (n) add_req(random_req(pit_pkg::OP_RESTORE, pick_holder(), 1'b0));
				n_gen += n;
			end else if (r < 26) begin
				// noise: any opcode, any holder
				op = pit_pkg::opcode_t'($urandom_range(3));
				add_req(random_req(op, pit_pkg::IDW'($urandom_range(255)), 1'b0));
				n_gen++;
			end else begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					add_req(random_req(pit_pkg::OP_APPLY, pick_holder(),
						$urandom_range(99) < 80));
				end else if (pick < 65) begin
					add_req(random_req(pit_pkg::OP_RESTORE, pick_holder(), 1'b0));
				end else if (pick < 82) begin
					add_req(random_req(pit_pkg::OP_QUERY, pick_holder(), 1'b0));
				end else begin
					add_req(random_req(pit_pkg::OP_WAITER, pick_holder(), 1'b0));
				end
				n_gen++;
			end
		end

		// single reset at the start of the run
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// wait for every transaction to be taken and answered
		while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray response
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog well beyond the slowest correct run
	initial begin
		#800000;
		$display("status: fail");
		$finish;
	end

endmodule
